// ===== hdl/triangle_tangent_binormal_assert.svh =====
// Assertion macros shared by the block's modules.
`ifndef TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH
`define TRIANGLE_TANGENT_BINORMAL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TTB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_tangent_binormal assertion failed");

// Next-cycle implication, checked out of reset.
`define TTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_tangent_binormal assertion failed");

`endif

// ===== hdl/ttb_pkg.sv =====
package ttb_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DET = 2'd1;
    localparam logic [1:0] ST_ZERO_LEN = 2'd2;

    // Normalized magnitudes land in [2^NORM_LO, 2^NORM_HI).
    localparam int NORM_HI = 30;
    localparam int NORM_LO = 29;
    localparam int FRAC_BITS = 14;
    localparam int Q_BITS = 15;
    localparam int OUT_W = 16;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== hdl/triangle_tangent_binormal.sv =====
// Channel  | Handshake          | Payload
// corner   | push / full        | pos_x, pos_y, pos_z, tex_u, tex_v
// result   | empty / pop        | tangent_xyz, binormal_xyz, status
//
// One result for every third corner. A corner transfers in the cycle it is offered
// unless full is high, which holds while the two-entry queue has two triangles waiting.
// The back sequencer runs the multiplier steps, then per vector the shift, squaring, root
// and division steps; a degenerate triangle goes from the multiplier steps straight to the write.
// A result not yet popped holds the back in its write step.
// Reset clears the corner count, the queue and the result slot.
module triangle_tangent_binormal #(
    parameter int POS_WIDTH = 16,
    parameter int UV_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] pos_z,
    input  logic signed [UV_WIDTH-1:0]  tex_u,
    input  logic signed [UV_WIDTH-1:0]  tex_v,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [15:0]          tangent_x,
    output logic signed [15:0]          tangent_y,
    output logic signed [15:0]          tangent_z,
    output logic signed [15:0]          binormal_x,
    output logic signed [15:0]          binormal_y,
    output logic signed [15:0]          binormal_z,
    output logic [1:0]                  status
);

    localparam int QW = 6 * (POS_WIDTH + 1) + 4 * (UV_WIDTH + 1);

    ttb_pkg::q_stat_t qst;
    logic q_wr;
    logic q_rd;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    ttb_front #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
        .qst(qst), .full(full), .q_wr(q_wr), .q_data(q_wdata)
    );

    ttb_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_wr), .wdata(q_wdata),
        .rd(q_rd), .rdata(q_rdata), .st(qst)
    );

    ttb_back #(.POS_WIDTH(POS_WIDTH), .UV_WIDTH(UV_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_data(q_rdata), .qst(qst), .q_rd(q_rd),
        .pop(pop), .empty(empty),
        .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
        .binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z),
        .status(status)
    );

endmodule

// ===== hdl/ttb_queue.sv =====
module ttb_queue #(
    parameter int W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [W-1:0]      wdata,
    input  logic              rd,
    output logic [W-1:0]      rdata,
    output ttb_pkg::q_stat_t  st
);

`include "triangle_tangent_binormal_assert.svh"

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   cnt_reg;

    assign st.full  = (cnt_reg == 2'd2);
    assign st.empty = (cnt_reg == 2'd0);
    assign rdata    = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                mem_reg[wptr_reg] <= wdata;
                wptr_reg <= ~wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (wr && !rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (rd && !wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    `TTB_ASSERT_IMPL(a_no_overflow, wr && st.full, 1'b0)
    `TTB_ASSERT_IMPL(a_no_underflow, rd && st.empty, 1'b0)

endmodule

// ===== hdl/ttb_front.sv =====
module ttb_front #(
    parameter int POS_WIDTH = 16,
    parameter int UV_WIDTH = 16,
    localparam int EW = POS_WIDTH + 1,
    localparam int DW = UV_WIDTH + 1,
    localparam int QW = 6 * EW + 4 * DW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic signed [POS_WIDTH-1:0] pos_x,
    input  logic signed [POS_WIDTH-1:0] pos_y,
    input  logic signed [POS_WIDTH-1:0] pos_z,
    input  logic signed [UV_WIDTH-1:0]  tex_u,
    input  logic signed [UV_WIDTH-1:0]  tex_v,
    input  ttb_pkg::q_stat_t            qst,
    output logic                        full,
    output logic                        q_wr,
    output logic [QW-1:0]               q_data
);

    logic [1:0] count_reg;
    logic signed [POS_WIDTH-1:0] px_reg [2];
    logic signed [POS_WIDTH-1:0] py_reg [2];
    logic signed [POS_WIDTH-1:0] pz_reg [2];
    logic signed [UV_WIDTH-1:0]  u_reg [2];
    logic signed [UV_WIDTH-1:0]  v_reg [2];
    logic take;

    assign full = qst.full;
    assign take = push && !qst.full;
    assign q_wr = take && (count_reg == 2'd2);

    // Edge vectors and UV deltas of the finished triangle, one extra bit each.
    always_comb
    begin
        q_data = {
            EW'(px_reg[1]) - EW'(px_reg[0]),
            EW'(py_reg[1]) - EW'(py_reg[0]),
            EW'(pz_reg[1]) - EW'(pz_reg[0]),
            EW'(pos_x) - EW'(px_reg[0]),
            EW'(pos_y) - EW'(py_reg[0]),
            EW'(pos_z) - EW'(pz_reg[0]),
            DW'(u_reg[1]) - DW'(u_reg[0]),
            DW'(v_reg[1]) - DW'(v_reg[0]),
            DW'(tex_u) - DW'(u_reg[0]),
            DW'(tex_v) - DW'(v_reg[0])
        };
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (take)
        begin
            if (count_reg == 2'd2)
            begin
                count_reg <= 2'd0;
            end
            else
            begin
                px_reg[count_reg[0]] <= pos_x;
                py_reg[count_reg[0]] <= pos_y;
                pz_reg[count_reg[0]] <= pos_z;
                u_reg[count_reg[0]]  <= tex_u;
                v_reg[count_reg[0]]  <= tex_v;
                count_reg <= count_reg + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/ttb_back.sv =====
module ttb_back #(
    parameter int POS_WIDTH = 16,
    parameter int UV_WIDTH = 16,
    localparam int EW = POS_WIDTH + 1,
    localparam int DW = UV_WIDTH + 1,
    localparam int QW = 6 * EW + 4 * DW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [QW-1:0]       q_data,
    input  ttb_pkg::q_stat_t    qst,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic signed [15:0]  tangent_x,
    output logic signed [15:0]  tangent_y,
    output logic signed [15:0]  tangent_z,
    output logic signed [15:0]  binormal_x,
    output logic signed [15:0]  binormal_y,
    output logic signed [15:0]  binormal_z,
    output logic [1:0]          status
);

`include "triangle_tangent_binormal_assert.svh"

    localparam int AW = (EW > DW) ? EW : DW;
    localparam int PW = 2 * AW;
    localparam int RW = PW + 1;
    localparam int MGW = (RW > ttb_pkg::NORM_HI) ? RW : ttb_pkg::NORM_HI;
    localparam int DVW = ttb_pkg::NORM_HI + ttb_pkg::FRAC_BITS + 2;
    localparam logic [63:0] LIM_HI = 64'd1 << ttb_pkg::NORM_HI;
    localparam logic [63:0] LIM_LO = 64'd1 << ttb_pkg::NORM_LO;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHECK, S_LOAD, S_SHIFT, S_SQ, S_SQRT,
        S_DIVLD, S_DIV, S_WRITE
    } state_t;

    state_t state_reg;
    logic [QW-1:0] ent_reg;
    logic [3:0] k_reg;
    logic signed [PW-1:0] p_reg;
    logic signed [RW-1:0] vec_reg [7];
    logic vsel_reg;
    logic [MGW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic [1:0] j_reg;
    logic [59:0] sqp_reg;
    logic [63:0] s_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0] jc_reg;
    logic [1:0] c_reg;
    logic [3:0] di_reg;
    logic [DVW-1:0] rem_reg;
    logic [ttb_pkg::Q_BITS-1:0] q_reg;
    logic signed [15:0] out_reg [6];
    logic [1:0] st_reg;
    logic res_valid_reg;
    logic signed [15:0] res_out_reg [6];
    logic [1:0] status_reg;

    logic signed [EW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [DW-1:0] d1u, d1v, d2u, d2v;
    logic signed [AW-1:0] opa, opb;
    logic [MGW-1:0] mx;
    logic [63:0] trial;
    logic [DVW-1:0] dsh;
    logic take;
    logic [ttb_pkg::Q_BITS-1:0] qn;
    logic mneg;
    logic t_zero, b_zero;
    logic signed [RW-1:0] vsrc [3];

    assign {e1x, e1y, e1z, e2x, e2y, e2z, d1u, d1v, d2u, d2v} = ent_reg;
    assign mneg = vec_reg[0][RW-1];
    assign t_zero = (vec_reg[1] == '0) && (vec_reg[2] == '0) && (vec_reg[3] == '0);
    assign b_zero = (vec_reg[4] == '0) && (vec_reg[5] == '0) && (vec_reg[6] == '0);
    assign q_rd = (state_reg == S_IDLE) && !qst.empty;
    assign empty = !res_valid_reg;

    always_comb
    begin
        case (k_reg)
            4'd0:    begin opa = AW'(d1u); opb = AW'(d2v); end
            4'd1:    begin opa = AW'(d2u); opb = AW'(d1v); end
            4'd2:    begin opa = AW'(e1x); opb = AW'(d2v); end
            4'd3:    begin opa = AW'(e2x); opb = AW'(d1v); end
            4'd4:    begin opa = AW'(e1y); opb = AW'(d2v); end
            4'd5:    begin opa = AW'(e2y); opb = AW'(d1v); end
            4'd6:    begin opa = AW'(e1z); opb = AW'(d2v); end
            4'd7:    begin opa = AW'(e2z); opb = AW'(d1v); end
            4'd8:    begin opa = AW'(e2x); opb = AW'(d1u); end
            4'd9:    begin opa = AW'(e1x); opb = AW'(d2u); end
            4'd10:   begin opa = AW'(e2y); opb = AW'(d1u); end
            4'd11:   begin opa = AW'(e1y); opb = AW'(d2u); end
            4'd12:   begin opa = AW'(e2z); opb = AW'(d1u); end
            default: begin opa = AW'(e1z); opb = AW'(d2u); end
        endcase
    end

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            vsrc[i] = vsel_reg ? vec_reg[4 + i] : vec_reg[1 + i];
        end
        trial = res_reg + bit_reg;
        dsh = DVW'(res_reg[31:0]) << di_reg;
        take = rem_reg >= dsh;
        qn = q_reg | (ttb_pkg::Q_BITS'(take) << di_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_WRITE) && (!res_valid_reg || pop))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!qst.empty)
                    begin
                        ent_reg <= q_data;
                        k_reg <= 4'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    p_reg <= opa * opb;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    // Even steps open a sum, odd steps subtract the second term.
                    if (!k_reg[0])
                    begin
                        vec_reg[k_reg[3:1]] <= RW'(p_reg);
                    end
                    else
                    begin
                        vec_reg[k_reg[3:1]] <= vec_reg[k_reg[3:1]] - RW'(p_reg);
                    end
                    k_reg <= k_reg + 4'd1;
                    state_reg <= (k_reg == 4'd13) ? S_CHECK : S_MUL;
                end
                S_CHECK:
                begin
                    vsel_reg <= 1'b0;
                    for (int i = 0; i < 6; i++)
                    begin
                        out_reg[i] <= '0;
                    end
                    if (vec_reg[0] == '0)
                    begin
                        st_reg <= ttb_pkg::ST_ZERO_DET;
                        state_reg <= S_WRITE;
                    end
                    else if (t_zero || b_zero)
                    begin
                        st_reg <= ttb_pkg::ST_ZERO_LEN;
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        st_reg <= ttb_pkg::ST_OK;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    // A negative determinant flips both vectors.
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vsrc[i][RW-1] ^ mneg;
                        mag_reg[i] <= vsrc[i][RW-1] ? MGW'(RW'(-vsrc[i])) : MGW'(RW'(vsrc[i]));
                    end
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (64'(mx) >= LIM_HI)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end
                    else if (64'(mx) < LIM_LO)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        j_reg <= 2'd0;
                        s_reg <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (j_reg != 2'd3)
                    begin
                        sqp_reg <= mag_reg[j_reg][29:0] * mag_reg[j_reg][29:0];
                    end
                    if (j_reg != 2'd0)
                    begin
                        s_reg <= s_reg + 64'(sqp_reg);
                    end
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd3)
                    begin
                        res_reg <= '0;
                        bit_reg <= 64'd1 << 62;
                        jc_reg <= 5'd31;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (s_reg >= trial)
                    begin
                        s_reg <= s_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    jc_reg <= jc_reg - 5'd1;
                    if (jc_reg == 5'd0)
                    begin
                        c_reg <= 2'd0;
                        state_reg <= S_DIVLD;
                    end
                end
                S_DIVLD:
                begin
                    // Numerator m * 2^14 plus half the root rounds to nearest.
                    rem_reg <= DVW'({mag_reg[c_reg][29:0], ttb_pkg::FRAC_BITS'(0)})
                             + DVW'(res_reg[31:1]);
                    q_reg <= '0;
                    di_reg <= 4'(ttb_pkg::Q_BITS - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (take)
                    begin
                        rem_reg <= rem_reg - dsh;
                    end
                    q_reg <= qn;
                    di_reg <= di_reg - 4'd1;
                    if (di_reg == 4'd0)
                    begin
                        out_reg[vsel_reg ? 3'(c_reg) + 3'd3 : 3'(c_reg)] <=
                            neg_reg[c_reg] ? -16'(qn) : 16'(qn);
                        if (c_reg != 2'd2)
                        begin
                            c_reg <= c_reg + 2'd1;
                            state_reg <= S_DIVLD;
                        end
                        else if (!vsel_reg)
                        begin
                            vsel_reg <= 1'b1;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    if (!res_valid_reg || pop)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            res_out_reg[i] <= out_reg[i];
                        end
                        status_reg <= st_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tangent_x  = res_out_reg[0];
    assign tangent_y  = res_out_reg[1];
    assign tangent_z  = res_out_reg[2];
    assign binormal_x = res_out_reg[3];
    assign binormal_y = res_out_reg[4];
    assign binormal_z = res_out_reg[5];
    assign status     = status_reg;

    `TTB_ASSERT_IMPL(a_err_zero, res_valid_reg && (status_reg != ttb_pkg::ST_OK),
        (tangent_x == 16'sd0) && (binormal_z == 16'sd0))
    `TTB_ASSERT_NEXT(a_result_held, res_valid_reg && !pop,
        res_valid_reg && $stable(status_reg) && $stable(tangent_x))

endmodule

// ===== sim/tb_triangle_tangent_binormal.sv =====
module tb_triangle_tangent_binormal;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CORNERS = 1086;
    localparam int QUIET_AFTER = 950;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] tx, ty, tz;
        logic signed [15:0] bx, by, bz;
        logic [1:0]         st;
    } frame_t;

    typedef struct {
        logic signed [15:0] px, py, pz, u, v;
        bit                 typed;
        frame_t             want;
    } corner_row_t;

    logic clk, rst_n, push, full, empty, pop;
    logic signed [15:0] pos_x, pos_y, pos_z, tex_u, tex_v;
    logic signed [15:0] tangent_x, tangent_y, tangent_z;
    logic signed [15:0] binormal_x, binormal_y, binormal_z;
    logic [1:0] status;

    frame_t frames_due[$];
    int errors = 0;
    int corners_in = 0;
    bit quiet = 0;

    // Mirror of the corner store.
    int corners_held = 0;
    longint held_p[2][3];
    longint held_t[2][2];

    triangle_tangent_binormal dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale a nonzero vector to unit length in Q1.14, rounding half away from zero.
    function automatic void unit_q14(input longint vec[3], output logic signed [15:0] o[3]);
        longint unsigned mag[3], mx, s, r, q;
        bit neg[3];
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = vec[i] < 0;
            mag[i] = neg[i] ? -vec[i] : vec[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        while (mx >= (64'd1 << ttb_pkg::NORM_HI))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << ttb_pkg::NORM_LO))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++)
            s += mag[i] * mag[i];
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 16384 + (r >> 1)) / r;
            o[i] = neg[i] ? -$signed(q[15:0]) : $signed(q[15:0]);
        end
    endfunction

    // Returns 1 and the frame when this corner closes a triangle.
    function automatic bit triangle_frame(input logic signed [15:0] px, py, pz, u, v,
                                          output frame_t f);
        longint p[3], e1[3], e2[3], t[3], b[3];
        longint d1u, d1v, d2u, d2v, det;
        logic signed [15:0] tn[3], bn[3];
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        f = '0;
        f.st = ttb_pkg::ST_OK;
        if (corners_held < 2)
        begin
            held_p[corners_held] = p;
            held_t[corners_held][0] = u;
            held_t[corners_held][1] = v;
            corners_held++;
            return 0;
        end
        corners_held = 0;
        d1u = held_t[1][0] - held_t[0][0];
        d1v = held_t[1][1] - held_t[0][1];
        d2u = longint'(u) - held_t[0][0];
        d2v = longint'(v) - held_t[0][1];
        det = d1u * d2v - d2u * d1v;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = held_p[1][i] - held_p[0][i];
            e2[i] = p[i] - held_p[0][i];
            t[i] = e1[i] * d2v - e2[i] * d1v;
            b[i] = e2[i] * d1u - e1[i] * d2u;
            if (det < 0)
            begin
                t[i] = -t[i];
                b[i] = -b[i];
            end
        end
        if (det == 0)
            f.st = ttb_pkg::ST_ZERO_DET;
        else if ((t[0] == 0 && t[1] == 0 && t[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0))
            f.st = ttb_pkg::ST_ZERO_LEN;
        else
        begin
            unit_q14(t, tn);
            unit_q14(b, bn);
            f.tx = tn[0]; f.ty = tn[1]; f.tz = tn[2];
            f.bx = bn[0]; f.by = bn[1]; f.bz = bn[2];
        end
        return 1;
    endfunction

    function automatic corner_row_t mk(input int px, py, pz, u, v);
        corner_row_t c;
        c.px = 16'(px); c.py = 16'(py); c.pz = 16'(pz); c.u = 16'(u); c.v = 16'(v);
        c.typed = 0;
        c.want = '0;
        return c;
    endfunction

    // Drives one corner and returns after its transfer edge.
    task automatic send_corner(input corner_row_t c);
        frame_t f;
        push <= 1;
        pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz;
        tex_u <= c.u; tex_v <= c.v;
        do
            @(negedge clk);
        while (full);
        @(posedge clk);
        corners_in++;
        if (triangle_frame(c.px, c.py, c.pz, c.u, c.v, f))
            frames_due.insert(frames_due.size(), c.typed ? c.want : f);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            push <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Sender.
    initial
    begin
        corner_row_t rows[$];
        corner_row_t c;
        int mode;
        rst_n = 0;
        push = 0; pop = 0;
        pos_x = 0; pos_y = 0; pos_z = 0; tex_u = 0; tex_v = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Degenerate triangle: determinant zero.
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0));
        c = mk(0, 0, 0, 0, 0); c.typed = 1; c.want.st = ttb_pkg::ST_ZERO_DET;
        rows.insert(rows.size(), c);
        // Coincident positions with distinct UVs: zero-length vectors.
        rows.insert(rows.size(), mk(100, -7, 3, 0, 0));
        rows.insert(rows.size(), mk(100, -7, 3, 4096, 0));
        c = mk(100, -7, 3, 0, 4096); c.typed = 1; c.want.st = ttb_pkg::ST_ZERO_LEN;
        rows.insert(rows.size(), c);
        // Axis-aligned triangle with positive determinant.
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(256, 0, 0, 4096, 0));
        c = mk(0, 256, 0, 0, 4096); c.typed = 1;
        c.want.tx = 16384; c.want.by = 16384; c.want.st = ttb_pkg::ST_OK;
        rows.insert(rows.size(), c);
        // Same triangle with swapped UVs, so the determinant is negative.
        rows.insert(rows.size(), mk(0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk(256, 0, 0, 0, 4096));
        c = mk(0, 256, 0, 4096, 0); c.typed = 1;
        c.want.ty = 16384; c.want.bx = 16384; c.want.st = ttb_pkg::ST_OK;
        rows.insert(rows.size(), c);
        // Field extremes, checked against the predictor.
        rows.insert(rows.size(), mk(-32768, -32768, -32768, -32768, -32768));
        rows.insert(rows.size(), mk(32767, 32767, -32768, 32767, -32768));
        rows.insert(rows.size(), mk(-32768, 32767, 32767, -32768, 32767));
        rows.insert(rows.size(), mk(32767, -32768, 32767, 32767, 32767));
        rows.insert(rows.size(), mk(-1, 0, -1, 0, -1));
        rows.insert(rows.size(), mk(1, 32767, -32768, -1, 1));

        foreach (rows[i])
        begin
            send_corner(rows[i]);
            sender_gap();
        end

        mode = 0;
        for (int n = 0; n < RANDOM_CORNERS; n++)
        begin
            if (n % 3 == 0)
                mode = $urandom_range(0, 9);
            c = mk($urandom, $urandom, $urandom, $urandom, $urandom);
            // Small coordinates now and then, and shared UVs or positions.
            if (mode == 1)
            begin
                c.px = 16'($signed(4'($urandom))); c.py = 16'($signed(4'($urandom)));
                c.pz = 16'($signed(4'($urandom))); c.u = 16'($signed(3'($urandom)));
                c.v = 16'($signed(3'($urandom)));
            end
            if (mode == 2 && n % 3 != 0)
            begin
                c.u = 16'sd1000; c.v = -16'sd1000;
            end
            if (mode == 3 && n % 3 != 0)
            begin
                c.px = -16'sd5; c.py = 16'sd77; c.pz = 16'sd0;
            end
            if (n == 600)
            begin
                // Let the block drain completely before going on.
                push <= 0;
                while (frames_due.size() != 0)
                    @(posedge clk);
            end
            if (n >= QUIET_AFTER)
                quiet = 1;
            send_corner(c);
            sender_gap();
        end
        push <= 0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("tb_triangle_tangent_binormal: done, clean");
        else
            $display("tb_triangle_tangent_binormal: done, errors");
        $finish;
    end

    // Receiver: random idle bursts, plus one long hold-off so the input backs up.
    initial
    begin
        frame_t got, want;
        int idle_left;
        bit held_once;
        idle_left = 0;
        held_once = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_once && corners_in >= 330)
            begin
                held_once = 1;
                idle_left = 600;
            end
            else if (idle_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                idle_left = $urandom_range(1, 15);
            if (idle_left > 0)
            begin
                idle_left--;
                pop <= 0;
            end
            else
                pop <= 1;
            @(negedge clk);
            if (pop && !empty)
            begin
                got = {tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z, status};
                if (frames_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no result, got %h", $realtime, got);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz)
                    begin
                        errors++;
                        $display("%0t: tangent expected %0d %0d %0d, got %0d %0d %0d", $realtime,
                                 want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
                    end
                    if (got.bx !== want.bx || got.by !== want.by || got.bz !== want.bz)
                    begin
                        errors++;
                        $display("%0t: binormal expected %0d %0d %0d, got %0d %0d %0d", $realtime,
                                 want.bx, want.by, want.bz, got.bx, got.by, got.bz);
                    end
                    if (got.st !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d", $realtime, want.st, got.st);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_triangle_tangent_binormal: done, errors");
                $finish;
            end
        end
    end

endmodule

// ===== triangle_tangent_binormal.f =====
+incdir+hdl
hdl/ttb_pkg.sv
hdl/ttb_queue.sv
hdl/ttb_front.sv
hdl/ttb_back.sv
hdl/triangle_tangent_binormal.sv
sim/tb_triangle_tangent_binormal.sv
